@@ sv/clb_pkg.sv @@
// Shared types and constants for the cell list binning block.
// Used by cell_list_binning and clb_axis_map; depends on nothing else.
`default_nettype none

package clb_pkg;

  // Fixed field widths of the beats.
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned PIDX_W    = 12;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned QCELL_W   = 6;
  localparam int unsigned OCELL_W   = 6;
  localparam int unsigned LINK_W    = 12;
  localparam int unsigned CPS_W     = 7;
  localparam int unsigned INV_W     = 16;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_SIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE  = 1'd1;
  localparam logic [CPS_W-1:0] CPS_RESET = 7'd64;
  localparam logic [INV_W-1:0] INV_RESET = 16'd16384;

  // Width of the clear generation tag kept with each cell head.
  localparam int unsigned EPOCH_W = 4;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_HEAD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ_LINK = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [PIDX_W-1:0]       particle_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [QCELL_W-1:0]      query_cell_x;
    logic [QCELL_W-1:0]      query_cell_y;
  } in_beat_t;

  typedef struct packed {
    logic [OCELL_W-1:0] cell_x;
    logic [OCELL_W-1:0] cell_y;
    logic [LINK_W-1:0]  link;
    logic               link_valid;
  } out_beat_t;

  // A list pointer: valid flag and particle number.
  typedef struct packed {
    logic              valid;
    logic [LINK_W-1:0] idx;
  } link_t;

  // A cell head entry: pointer tagged with the clear generation that wrote it.
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    link_t              link;
  } head_t;

endpackage

`default_nettype wire

@@ sv/cell_list_binning.sv @@
// Cell list binning. Each item passes in turn through the accept cycle, the
// coordinate multipliers, the read of the head and link memories, and
// write-back with loading of the result register, which waits while the
// output stalls; the next item is accepted in the cycle after write-back.
// Cell heads live in a GRID_SIDE*GRID_SIDE entry memory tagged with a 4-bit
// clear generation, so a clear normally passes through the same steps. After
// reset, and on every 16th clear, a sweep writes every head entry empty, one
// entry per cycle, while no item is accepted.
// Configuration writes are taken at any time but must only be issued while idle.
// Depends on clb_pkg, clb_ram and clb_axis_map.
`default_nettype none

module cell_list_binning #(
  parameter int unsigned GRID_SIDE     = 64,
  parameter int unsigned MAX_PARTICLES = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [clb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [clb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire clb_pkg::in_beat_t                 in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output clb_pkg::out_beat_t                     out_data_o
);

  import clb_pkg::*;

  localparam int unsigned CELL_W     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned HEAD_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int unsigned HEAD_AW    = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
  localparam int unsigned LINK_AW    = $clog2(MAX_PARTICLES);
  localparam int unsigned QCMP_W     = 10;
  localparam int unsigned PCMP_W     = 17;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CPS_W-1:0]   cps_q;
  logic [INV_W-1:0]   inv_q;
  in_beat_t           item_q;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [HEAD_AW-1:0] sweep_q, sweep_d;
  logic [HEAD_AW-1:0] slot_q;
  logic               q_ok_q;
  logic               p_ok_q;
  logic               out_valid_q;
  out_beat_t          out_q;

  logic [CELL_W-1:0]  cell_x, cell_y;
  logic [HEAD_AW-1:0] ins_slot, qry_slot, rd_slot;
  logic               q_ok, p_ok;
  logic               accept;
  logic               wb_go;
  logic               head_live;
  link_t              entry;
  out_beat_t          res;

  logic               head_we;
  logic [HEAD_AW-1:0] head_waddr;
  head_t              head_wdata;
  head_t              head_rdata;
  logic               link_we;
  link_t              link_rdata;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign wb_go      = (state_q == S_WB) && (!out_valid_q || !out_stall_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= CPS_RESET;
      inv_q <= INV_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CELLS_PER_SIDE: cps_q <= cfg_wdata_i[CPS_W-1:0];
        CFG_INV_CELL_SIZE:  inv_q <= cfg_wdata_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  // One mapping lane per axis.
  clb_axis_map #(.GRID_SIDE(GRID_SIDE)) u_map_x (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL),
    .pos_i  (item_q.pos_x),
    .inv_i  (inv_q),
    .cps_i  (cps_q),
    .cell_o (cell_x)
  );

  clb_axis_map #(.GRID_SIDE(GRID_SIDE)) u_map_y (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MUL),
    .pos_i  (item_q.pos_y),
    .inv_i  (inv_q),
    .cps_i  (cps_q),
    .cell_o (cell_y)
  );

  // Memory addresses for the read cycle.
  assign ins_slot = HEAD_AW'(cell_x) * HEAD_AW'(GRID_SIDE) + HEAD_AW'(cell_y);
  assign qry_slot = HEAD_AW'(item_q.query_cell_x) * HEAD_AW'(GRID_SIDE)
                  + HEAD_AW'(item_q.query_cell_y);
  assign rd_slot  = (item_q.kind == KIND_READ_HEAD) ? qry_slot : ins_slot;
  assign q_ok     = (QCMP_W'(item_q.query_cell_x) < QCMP_W'(GRID_SIDE))
                 && (QCMP_W'(item_q.query_cell_y) < QCMP_W'(GRID_SIDE));
  assign p_ok     = PCMP_W'(item_q.particle_index) < PCMP_W'(MAX_PARTICLES);

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      slot_q <= rd_slot;
      q_ok_q <= q_ok;
      p_ok_q <= p_ok;
    end
  end

  // A head is live only if written in the current clear generation.
  assign head_live = head_rdata.link.valid && (head_rdata.epoch == epoch_q);

  // Result of the item in write-back.
  always_comb begin
    entry = '0;
    res   = '0;
    case (item_q.kind)
      KIND_INSERT: begin
        if (head_live) begin
          entry = head_rdata.link;
        end
        res.cell_x = OCELL_W'(cell_x);
        res.cell_y = OCELL_W'(cell_y);
      end
      KIND_READ_HEAD: begin
        if (head_live && q_ok_q) begin
          entry = head_rdata.link;
        end
      end
      KIND_READ_LINK: begin
        if (p_ok_q && link_rdata.valid) begin
          entry = link_rdata;
        end
      end
      default: ;
    endcase
    res.link_valid = entry.valid;
    res.link       = entry.valid ? entry.idx : '0;
  end

  // Head memory writes: sweep entries empty, or push the inserted particle.
  assign link_we = wb_go && (item_q.kind == KIND_INSERT) && p_ok_q;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = slot_q;
    head_wdata = '0;
    if (state_q == S_SWEEP) begin
      head_we    = 1'b1;
      head_waddr = sweep_q;
    end else if (link_we) begin
      head_we               = 1'b1;
      head_wdata.epoch      = epoch_q;
      head_wdata.link.valid = 1'b1;
      head_wdata.link.idx   = item_q.particle_index;
    end
  end

  clb_ram #(.WIDTH($bits(head_t)), .DEPTH(HEAD_DEPTH)) u_heads (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (state_q == S_RD),
    .raddr_i (rd_slot),
    .rdata_o (head_rdata)
  );

  clb_ram #(.WIDTH($bits(link_t)), .DEPTH(MAX_PARTICLES)) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (LINK_AW'(item_q.particle_index)),
    .wdata_i (entry),
    .re_i    (state_q == S_RD),
    .raddr_i (LINK_AW'(item_q.particle_index)),
    .rdata_o (link_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    epoch_d = epoch_q;
    sweep_d = sweep_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_MUL;
        end
      end
      S_MUL: state_d = S_RD;
      S_RD:  state_d = S_WB;
      S_WB: begin
        if (wb_go) begin
          state_d = S_IDLE;
          if (item_q.kind == KIND_CLEAR) begin
            if (epoch_q == '1) begin
              state_d = S_SWEEP;
              epoch_d = '0;
              sweep_d = '0;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end
      S_SWEEP: begin
        sweep_d = sweep_q + HEAD_AW'(1);
        if (sweep_q == HEAD_AW'(HEAD_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      epoch_q <= '0;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      epoch_q <= epoch_d;
      sweep_q <= sweep_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_go) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A new result appears only out of write-back.
  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_WB))
    else $error("result register loaded outside write-back");

  // A clear either advances the generation or starts a sweep.
  a_clear_epoch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wb_go && (item_q.kind == KIND_CLEAR)) |=>
      ((state_q == S_SWEEP) || (epoch_q == $past(epoch_q) + EPOCH_W'(1))))
    else $error("clear did not retire the old head generation");

  // Inserts write a live head tagged with the current generation.
  a_head_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_we && (state_q != S_SWEEP)) |->
      (head_wdata.link.valid && (head_wdata.epoch == epoch_q)))
    else $error("head written with a stale or empty entry");
`endif

endmodule

`default_nettype wire

@@ sv/clb_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`default_nettype none

module clb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/clb_axis_map.sv @@
// Maps one coordinate to a cell index: scale by the reciprocal, floor, clamp.
// Depends on clb_pkg for field widths.
`default_nettype none

module clb_axis_map #(
  parameter int unsigned GRID_SIDE = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  en_i,
  input  wire logic signed [clb_pkg::POS_W-1:0]      pos_i,
  input  wire logic [clb_pkg::INV_W-1:0]             inv_i,
  input  wire logic [clb_pkg::CPS_W-1:0]             cps_i,
  output logic [((GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1)-1:0] cell_o
);

  import clb_pkg::*;

  localparam int unsigned CELL_W = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned PROD_W = POS_W + INV_W + 1;
  localparam int unsigned FRAC_W = 24;
  localparam int unsigned QUOT_W = PROD_W - FRAC_W;

  logic signed [PROD_W-1:0] prod_q;
  logic [QUOT_W-1:0]        quot;
  logic [QUOT_W-1:0]        cps_ext;
  logic [QUOT_W-1:0]        side_m1;
  logic [QUOT_W-1:0]        clamped;

  // Q7.16 times Q8.8 gives an exact Q.24 product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= pos_i * $signed({1'b0, inv_i});
    end
  end

  // The floor is the integer part of the product.
  assign quot    = prod_q[PROD_W-1:FRAC_W];
  assign cps_ext = QUOT_W'(cps_i);

  // Active side: zero acts as one, values beyond the grid act as the grid side.
  always_comb begin
    if (cps_ext == '0) begin
      side_m1 = '0;
    end else if (cps_ext > QUOT_W'(GRID_SIDE)) begin
      side_m1 = QUOT_W'(GRID_SIDE - 1);
    end else begin
      side_m1 = cps_ext - QUOT_W'(1);
    end
  end

  // Negative products land in cell zero, large ones in the last cell.
  always_comb begin
    if (prod_q[PROD_W-1]) begin
      clamped = '0;
    end else if (quot > side_m1) begin
      clamped = side_m1;
    end else begin
      clamped = quot;
    end
  end

  assign cell_o = CELL_W'(clamped);

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for cell_list_binning: directed rows, then random phases.
// Each phase sets the grid registers and runs random beats; results are checked
// against a behavioral binning model kept here. Depends on clb_pkg and the block.

module tb_top;
  import clb_pkg::*;

  localparam int unsigned GRID        = 64;
  localparam int unsigned NPART       = 4096;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 54;
  localparam int unsigned DIR_ROWS    = 19;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

  // One directed row: the beat, and a typed-in result where it is obvious.
  typedef struct packed {
    in_beat_t  beat;
    logic      literal;
    out_beat_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_beat_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_beat;

  // Binning model state.
  logic [CPS_W-1:0]  cps_reg = CPS_RESET;
  logic [INV_W-1:0]  inv_reg = INV_RESET;
  logic [LINK_W:0]   head_mem [GRID*GRID];
  logic [LINK_W:0]   link_mem [NPART];
  bit                link_written [NPART];
  int unsigned       linked_ids [$];
  logic [OCELL_W-1:0] last_cx = '0;
  logic [OCELL_W-1:0] last_cy = '0;

  out_beat_t   expected_bins [$];
  int unsigned n_results = 0;
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          long_hold_done = 1'b0;
  dir_row_t    dir_tab [DIR_ROWS];

  cell_list_binning #(
    .GRID_SIDE    (GRID),
    .MAX_PARTICLES(NPART)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // A register value of zero acts as one cell, anything above the grid as the grid.
  function automatic int unsigned active_side();
    if (cps_reg == 0) return 1;
    if (cps_reg > GRID) return GRID;
    return cps_reg;
  endfunction

  // Scale, floor by arithmetic shift and clamp one coordinate to a cell number.
  function automatic logic [OCELL_W-1:0] coord_to_cell(logic signed [POS_W-1:0] pos);
    longint prod;
    longint c;
    prod = longint'(pos) * longint'({48'b0, inv_reg});
    if (prod < 0) return '0;
    c = prod >>> 24;
    if (c > longint'(active_side()) - 1) c = longint'(active_side()) - 1;
    return c[OCELL_W-1:0];
  endfunction

  // Apply one beat to the model and return the result it produces.
  function automatic out_beat_t bin_predict(in_beat_t b);
    out_beat_t       r;
    logic [LINK_W:0] entry;
    int unsigned     slot;
    r = '0;
    entry = '0;
    case (b.kind)
      KIND_CLEAR: begin
        foreach (head_mem[i]) head_mem[i] = '0;
      end
      KIND_INSERT: begin
        r.cell_x = coord_to_cell(b.pos_x);
        r.cell_y = coord_to_cell(b.pos_y);
        slot = r.cell_x * GRID + r.cell_y;
        entry = head_mem[slot];
        link_mem[b.particle_index] = entry;
        if (!link_written[b.particle_index]) begin
          link_written[b.particle_index] = 1'b1;
          linked_ids.push_back(b.particle_index);
        end
        head_mem[slot] = {1'b1, b.particle_index};
        last_cx = r.cell_x;
        last_cy = r.cell_y;
      end
      KIND_READ_HEAD: begin
        entry = head_mem[b.query_cell_x * GRID + b.query_cell_y];
      end
      default: begin
        entry = link_mem[b.particle_index];
      end
    endcase
    r.link_valid = entry[LINK_W];
    r.link = entry[LINK_W] ? entry[LINK_W-1:0] : '0;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [KIND_W-1:0] k, int unsigned p,
                                      logic signed [POS_W-1:0] px,
                                      logic signed [POS_W-1:0] py,
                                      int unsigned qx, int unsigned qy, logic lit,
                                      int unsigned cx, int unsigned cy,
                                      int unsigned lnk, logic lv);
    dir_row_t r;
    r.beat.kind = k;
    r.beat.particle_index = p[PIDX_W-1:0];
    r.beat.pos_x = px;
    r.beat.pos_y = py;
    r.beat.query_cell_x = qx[QCELL_W-1:0];
    r.beat.query_cell_y = qy[QCELL_W-1:0];
    r.literal = lit;
    r.want.cell_x = cx[OCELL_W-1:0];
    r.want.cell_y = cy[OCELL_W-1:0];
    r.want.link = lnk[LINK_W-1:0];
    r.want.link_valid = lv;
    return r;
  endfunction

  // Coordinates mostly land a cell or two around the grid at the current scale.
  function automatic logic signed [POS_W-1:0] draw_pos();
    longint w;
    longint c;
    longint v;
    if (inv_reg == 0 || $urandom_range(0, 4) == 0) return POS_W'($urandom);
    w = (longint'(1) << 24) / longint'(inv_reg);
    c = longint'($urandom_range(0, active_side() + 3)) - 2;
    v = c * w + longint'($urandom_range(0, int'(w) - 1));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[POS_W-1:0];
  endfunction

  // Random beat: mostly inserts and reads that follow existing lists, some clears.
  function automatic in_beat_t draw_item();
    in_beat_t    b;
    int unsigned r;
    b.particle_index = $urandom_range(0, 2) == 0 ? PIDX_W'($urandom_range(0, 63))
                                                 : PIDX_W'($urandom);
    b.pos_x = draw_pos();
    b.pos_y = draw_pos();
    b.query_cell_x = QCELL_W'($urandom);
    b.query_cell_y = QCELL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      b.kind = KIND_CLEAR;
    end else if (r < 50 || linked_ids.size() == 0) begin
      b.kind = KIND_INSERT;
    end else if (r < 75) begin
      b.kind = KIND_READ_HEAD;
      if ($urandom_range(0, 4) < 3) begin
        b.query_cell_x = last_cx;
        b.query_cell_y = last_cy;
      end
    end else begin
      b.kind = KIND_READ_LINK;
      b.particle_index = PIDX_W'(linked_ids[$urandom_range(0, linked_ids.size() - 1)]);
    end
    return b;
  endfunction

  // Offer one beat, after a random gap if tx_idle is set, and record its expected result on acceptance.
  task automatic drive_item(input in_beat_t b, input logic lit, input out_beat_t want);
    int unsigned gap;
    out_beat_t   pred;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (in_stall);
    pred = bin_predict(b);
    expected_bins.push_back(lit ? want : pred);
  endtask

  // Let every pending result drain, plus the pipeline depth, with the input idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers on consecutive edges while the block is idle.
  task automatic write_grid(input logic [CPS_W-1:0] cps, input logic [INV_W-1:0] inv);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_CELLS_PER_SIDE;
    cfg_wdata <= CFG_DATA_W'(cps);
    @(posedge clk);
    cfg_idx <= CFG_INV_CELL_SIZE;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    cps_reg = cps;
    inv_reg = inv;
  endtask

  // Result side: random stall before every beat if rx_idle is set, one long hold-off to back up the block.
  // Sampling starts once reset is released.
  initial begin
    out_beat_t   want;
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = rx_idle ? $urandom_range(0, 11) : 0;
      if (!long_hold_done && n_results == 200) begin
        hold = 400;
        long_hold_done = 1'b1;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      n_results++;
      if (expected_bins.size() == 0) begin
        $error("result beat with nothing expected: %p", out_beat);
        n_fail++;
      end else begin
        want = expected_bins.pop_front();
        if (out_beat.cell_x !== want.cell_x) begin
          $error("cell_x: expected %0d, got %0d", want.cell_x, out_beat.cell_x);
          n_fail++;
        end
        if (out_beat.cell_y !== want.cell_y) begin
          $error("cell_y: expected %0d, got %0d", want.cell_y, out_beat.cell_y);
          n_fail++;
        end
        if (out_beat.link !== want.link) begin
          $error("link: expected %0d, got %0d", want.link, out_beat.link);
          n_fail++;
        end
        if (out_beat.link_valid !== want.link_valid) begin
          $error("link_valid: expected %0d, got %0d", want.link_valid, out_beat.link_valid);
          n_fail++;
        end
      end
    end
  end

  // Watchdog: covers the clearing sweeps after reset and on every 16th clear.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [CPS_W-1:0] cps;
    logic [INV_W-1:0] inv;
    foreach (head_mem[i]) head_mem[i] = '0;
    foreach (link_mem[i]) link_mem[i] = '0;
    foreach (link_written[i]) link_written[i] = 1'b0;

    // Directed rows under the reset setting: 64 cells per side, cell width 1/64.
    dir_tab = '{
      mk_row(KIND_READ_HEAD, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0),
      mk_row(KIND_READ_HEAD, 0, 0, 0, 63, 63, 1, 0, 0, 0, 0),
      mk_row(KIND_INSERT, 0, POS_MAX, POS_MAX, 0, 0, 1, 63, 63, 0, 0),
      mk_row(KIND_INSERT, 4095, POS_MIN, POS_MIN, 0, 0, 1, 0, 0, 0, 0),
      mk_row(KIND_INSERT, 1, POS_MAX, POS_MAX, 0, 0, 1, 63, 63, 0, 1),
      mk_row(KIND_READ_HEAD, 0, 0, 0, 63, 63, 1, 0, 0, 1, 1),
      mk_row(KIND_READ_LINK, 1, 0, 0, 0, 0, 1, 0, 0, 0, 1),
      mk_row(KIND_READ_LINK, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0),
      mk_row(KIND_INSERT, 2, 0, 0, 0, 0, 1, 0, 0, 4095, 1),
      mk_row(KIND_INSERT, 3, 1024, 1023, 0, 0, 0, 0, 0, 0, 0),
      mk_row(KIND_INSERT, 4, -1, 5120, 0, 0, 0, 0, 0, 0, 0),
      mk_row(KIND_READ_HEAD, 0, 0, 0, 63, 0, 0, 0, 0, 0, 0),
      mk_row(KIND_READ_HEAD, 0, 0, 0, 0, 63, 0, 0, 0, 0, 0),
      mk_row(KIND_READ_LINK, 4095, 0, 0, 0, 0, 1, 0, 0, 0, 0),
      mk_row(KIND_CLEAR, 4095, POS_MAX, POS_MIN, 63, 63, 1, 0, 0, 0, 0),
      mk_row(KIND_READ_HEAD, 0, 0, 0, 63, 63, 1, 0, 0, 0, 0),
      mk_row(KIND_READ_LINK, 2, 0, 0, 0, 0, 1, 0, 0, 4095, 1),
      mk_row(KIND_INSERT, 5, POS_MAX, POS_MIN, 0, 0, 1, 63, 0, 0, 0),
      mk_row(KIND_READ_LINK, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      drive_item(dir_tab[i].beat, dir_tab[i].literal, dir_tab[i].want);
    end
    drain();

    // Random phases: extremes of both registers first, then random settings, then the reset one.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin cps = 1;   inv = 16384; end
        1: begin cps = 64;  inv = 65535; end
        2: begin cps = 0;   inv = 256;   end
        3: begin cps = 127; inv = 1;     end
        4: begin cps = 64;  inv = 0;     end
        5: begin cps = CPS_W'($urandom_range(1, 64)); inv = INV_W'($urandom); end
        6: begin cps = CPS_W'($urandom_range(0, 127)); inv = INV_W'($urandom); end
        default: begin cps = CPS_RESET; inv = INV_RESET; end
      endcase
      write_grid(cps, inv);
      tx_idle = (ph % 3) != 0;
      rx_idle = (ph % 3) != 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        drive_item(draw_item(), 1'b0, '0);
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (n_fail == 0 && expected_bins.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
